>>> rtl/round_robin_idle_worker_dispatcher_unit_assert.svh
// Assertion macros shared by the dispatcher RTL.
// Each macro expects signals named clk and arst_n in the enclosing module.
`ifndef ROUND_ROBIN_IDLE_WORKER_DISPATCHER_UNIT_ASSERT_SVH
`define ROUND_ROBIN_IDLE_WORKER_DISPATCHER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RRIWD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RRIWD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/rriwd_pkg.sv
// Package of the round-robin idle-worker dispatcher: field widths, codes,
// state encoding and the queue control struct. Depends on nothing.
`default_nettype none

package rriwd_pkg;

	// Field widths of the item and result channels.
	localparam int CMD_W   = 2;
	localparam int ID_W    = 32;
	localparam int TOK_W   = 16;
	localparam int WIDX_W  = 4;
	localparam int KIND_W  = 3;
	localparam int LEVEL_W = 7;
	localparam int WC_W    = 5;
	localparam int ENTRY_W = ID_W + TOK_W;

	// Defaults for the top-level parameters.
	localparam int MAX_WORKERS_DEF = 16;
	localparam int QUEUE_DEPTH_DEF = 64;

	// Worker count after reset.
	localparam logic [WC_W-1:0] WC_RESET = 5'd16;

	typedef enum logic [CMD_W-1:0] {
		CMD_REQUEST = 2'd0,
		CMD_DONE    = 2'd1,
		CMD_END     = 2'd2,
		CMD_TICK    = 2'd3
	} cmd_e_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_NONE     = 3'd0,
		KIND_DISPATCH = 3'd1,
		KIND_STOP     = 3'd2,
		KIND_DROPPED  = 3'd3,
		KIND_BAD_DONE = 3'd4
	} kind_e_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_READ = 2'd1,
		S_MOD  = 2'd2
	} state_e_t;

	typedef struct packed {
		logic push;
		logic pop;
	} queue_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/rriwd_if.sv
// Handshake channels of the dispatcher: command items, result items and
// the worker-count write channel. Depends on rriwd_pkg for field widths.
`default_nettype none

interface rriwd_cmd_if;
	logic                          valid;
	logic                          ready;
	logic [rriwd_pkg::CMD_W-1:0]   command;
	logic [rriwd_pkg::ID_W-1:0]    request_id;
	logic [rriwd_pkg::TOK_W-1:0]   token_count;
	logic [rriwd_pkg::WIDX_W-1:0]  done_worker;

	modport source(output valid, command, request_id, token_count, done_worker,
		input ready);
	modport sink(input valid, command, request_id, token_count, done_worker,
		output ready);
endinterface

interface rriwd_res_if;
	logic                           valid;
	logic                           ready;
	logic [rriwd_pkg::KIND_W-1:0]   kind;
	logic [rriwd_pkg::WIDX_W-1:0]   target_worker;
	logic [rriwd_pkg::ID_W-1:0]     sent_id;
	logic [rriwd_pkg::TOK_W-1:0]    sent_tokens;
	logic [rriwd_pkg::LEVEL_W-1:0]  queue_level;

	modport source(output valid, kind, target_worker, sent_id, sent_tokens,
		queue_level, input ready);
	modport sink(input valid, kind, target_worker, sent_id, sent_tokens,
		queue_level, output ready);
endinterface

interface rriwd_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [rriwd_pkg::WC_W-1:0]  worker_total;

	modport source(output valid, worker_total, input ready);
	modport sink(input valid, worker_total, output ready);
endinterface

`default_nettype wire

>>> rtl/round_robin_idle_worker_dispatcher_unit.sv
// Round-robin idle-worker dispatcher, top level.
// Channel cmd takes items: a new request, a worker-finished event, the end
// of input, or an idle tick. Every accepted item gives exactly one result
// item on channel res: dispatch (with target worker, request id and token
// count), stop all, queue-full drop, bad done, or nothing; each result also
// carries the number of requests still waiting. Channel cfg writes the
// number of workers in use (0 acts as 1, values above MAX_WORKERS as
// MAX_WORKERS); it is written only while no item is in flight.
// A result item is loaded into the result register once its item has passed
// the read stage, which reads the head slot of the request memory; the block
// takes no new item until the last one has left the read stage. After a
// worker-count write the block takes no item until the rotating start
// position has been reduced below the new count, one subtraction a cycle.
// Reset clears all workers to idle, empties the queue, sets the worker
// count to 16 and clears the end and stop marks. After stop-all every item
// gives a nothing result with the queue level.
// A stalled receiver holds the result register; one further item may be
// accepted meanwhile, and the block then waits until the register drains.
// Depends on rriwd_pkg, rriwd_if, rriwd_pick and rriwd_queue.
`default_nettype none

`include "round_robin_idle_worker_dispatcher_unit_assert.svh"

module round_robin_idle_worker_dispatcher_unit #(
	parameter int MAX_WORKERS = rriwd_pkg::MAX_WORKERS_DEF,
	parameter int QUEUE_DEPTH = rriwd_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	rriwd_cmd_if.sink   cmd,
	rriwd_res_if.source res,
	rriwd_cfg_if.sink   cfg
);

	localparam int WW = $clog2(MAX_WORKERS);
	localparam int NW = $clog2(MAX_WORKERS + 1);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int XW = (WW > rriwd_pkg::WIDX_W) ? WW : rriwd_pkg::WIDX_W;

	rriwd_pkg::state_e_t state_q, state_d;

	logic [rriwd_pkg::WC_W-1:0] wc_q;
	logic [NW-1:0]              n_eff;
	logic [WW-1:0]              ptr_q;
	logic [WW-1:0]              start_q;
	logic [MAX_WORKERS-1:0]     busy_q;
	logic                       ended_q;
	logic                       stopped_q;

	logic cmd_acc;
	logic cfg_acc;
	logic load_out;
	logic start_big;

	// Step decision for the item on the command channel.
	logic [MAX_WORKERS-1:0]      busy_done;
	logic [MAX_WORKERS-1:0]      busy_nxt;
	logic [XW-1:0]               widx;
	logic                        st_push;
	logic                        st_try;
	logic                        st_ended;
	logic                        st_stop;
	logic                        st_disp;
	rriwd_pkg::kind_e_t          st_kind;
	logic                        pick_found;
	logic [WW-1:0]               pick_idx;
	logic [NW:0]                 idx_inc;
	logic [WW-1:0]               ptr_nxt;
	logic [CW-1:0]               q_count;
	logic [CW-1:0]               count_after;
	logic                        q_full;
	rriwd_pkg::queue_ctrl_t      q_ctrl;
	logic [rriwd_pkg::ENTRY_W-1:0] q_rdata;

	// Item in the read stage.
	rriwd_pkg::kind_e_t             kind_s1;
	logic [WW-1:0]                  tgt_s1;
	logic                           fwd_s1;
	logic [rriwd_pkg::ENTRY_W-1:0]  fwd_data_s1;
	logic [rriwd_pkg::LEVEL_W-1:0]  level_s1;
	logic [rriwd_pkg::ENTRY_W-1:0]  entry_s1;

	// Result register.
	logic                           out_valid_q;
	logic [rriwd_pkg::KIND_W-1:0]   out_kind_q;
	logic [rriwd_pkg::WIDX_W-1:0]   out_tgt_q;
	logic [rriwd_pkg::ID_W-1:0]     out_id_q;
	logic [rriwd_pkg::TOK_W-1:0]    out_tok_q;
	logic [rriwd_pkg::LEVEL_W-1:0]  out_level_q;

	// Effective worker count.
	always_comb begin
		if (wc_q == '0) begin
			n_eff = NW'(1);
		end else if (int'(wc_q) > MAX_WORKERS) begin
			n_eff = NW'(MAX_WORKERS);
		end else begin
			n_eff = NW'(wc_q);
		end
	end

	assign start_big = ({1'b0, start_q} >= (WW + 1)'(n_eff));

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			rriwd_pkg::S_IDLE: begin
				if (cfg_acc) begin
					state_d = rriwd_pkg::S_MOD;
				end else if (cmd_acc) begin
					state_d = rriwd_pkg::S_READ;
				end
			end
			rriwd_pkg::S_READ: begin
				if (load_out) begin
					state_d = rriwd_pkg::S_IDLE;
				end
			end
			rriwd_pkg::S_MOD: begin
				if (!cfg_acc && !start_big) begin
					state_d = rriwd_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = rriwd_pkg::S_IDLE;
			end
		endcase
	end

	// Handshake outputs of the state machine.
	always_comb begin
		cmd.ready = (state_q == rriwd_pkg::S_IDLE) && !cfg.valid;
		cfg.ready = (state_q != rriwd_pkg::S_READ);
		load_out  = (state_q == rriwd_pkg::S_READ) && (!out_valid_q || res.ready);
	end

	assign cmd_acc = cmd.valid && cmd.ready;
	assign cfg_acc = cfg.valid && cfg.ready;

	rriwd_pick #(
		.MAX_WORKERS(MAX_WORKERS)
	) u_pick (
		.busy    (busy_done),
		.count_n (n_eff),
		.start   (start_q),
		.found   (pick_found),
		.idx     (pick_idx)
	);

	assign q_full = (q_count == CW'(QUEUE_DEPTH));

	// Decode of one item: queue push, done handling, dispatch and stop.
	always_comb begin
		busy_done = busy_q;
		st_push   = 1'b0;
		st_try    = 1'b0;
		st_ended  = ended_q;
		st_kind   = rriwd_pkg::KIND_NONE;
		widx      = XW'(cmd.done_worker);
		if (!stopped_q) begin
			case (cmd.command)
				rriwd_pkg::CMD_REQUEST: begin
					st_try = 1'b1;
					if (q_full) begin
						st_push = pick_found;
						if (!pick_found) begin
							st_kind = rriwd_pkg::KIND_DROPPED;
						end
					end else begin
						st_push = 1'b1;
					end
				end
				rriwd_pkg::CMD_DONE: begin
					if (int'(cmd.done_worker) >= MAX_WORKERS || !busy_q[widx[WW-1:0]]) begin
						st_kind = rriwd_pkg::KIND_BAD_DONE;
					end else begin
						busy_done[widx[WW-1:0]] = 1'b0;
						st_try = 1'b1;
					end
				end
				rriwd_pkg::CMD_END: begin
					st_ended = 1'b1;
					st_try   = 1'b1;
				end
				default: begin
					st_try = 1'b1;
				end
			endcase
		end
		st_disp = st_try && pick_found && ((q_count != '0) || st_push);
		st_stop = st_try && !st_disp && st_ended && (q_count == '0) && !st_push
			&& (busy_done == '0);
		if (st_disp) begin
			st_kind = rriwd_pkg::KIND_DISPATCH;
		end else if (st_stop) begin
			st_kind = rriwd_pkg::KIND_STOP;
		end
	end

	// Busy set for the dispatched worker, pointer one past it.
	always_comb begin
		busy_nxt = busy_done;
		if (st_disp) begin
			busy_nxt[pick_idx] = 1'b1;
		end
		idx_inc = (NW + 1)'(pick_idx) + (NW + 1)'(1);
		ptr_nxt = (idx_inc == (NW + 1)'(n_eff)) ? '0 : WW'(idx_inc);
	end

	always_comb begin
		count_after = q_count + CW'(st_push) - CW'(st_disp);
		q_ctrl.push = cmd_acc && st_push;
		q_ctrl.pop  = cmd_acc && st_disp;
	end

	rriwd_queue #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (q_ctrl),
		.wdata  ({cmd.request_id, cmd.token_count}),
		.rdata  (q_rdata),
		.count  (q_count)
	);

	// Control state: workers, pointer, marks, worker count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= rriwd_pkg::S_IDLE;
			wc_q      <= rriwd_pkg::WC_RESET;
			ptr_q     <= '0;
			start_q   <= '0;
			busy_q    <= '0;
			ended_q   <= 1'b0;
			stopped_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_acc) begin
				wc_q    <= cfg.worker_total;
				start_q <= ptr_q;
			end else if (state_q == rriwd_pkg::S_MOD && start_big) begin
				start_q <= WW'((NW + 1)'(start_q) - (NW + 1)'(n_eff));
			end
			if (cmd_acc) begin
				busy_q    <= busy_nxt;
				ended_q   <= st_ended;
				stopped_q <= stopped_q || st_stop;
				if (st_disp) begin
					ptr_q   <= ptr_nxt;
					start_q <= ptr_nxt;
				end
			end
		end
	end

	// Read stage: what the result needs besides the memory data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_s1 <= rriwd_pkg::KIND_NONE;
		end else if (cmd_acc) begin
			kind_s1 <= st_kind;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			tgt_s1      <= pick_idx;
			fwd_s1      <= st_disp && st_push && (q_count == '0);
			fwd_data_s1 <= {cmd.request_id, cmd.token_count};
			level_s1    <= rriwd_pkg::LEVEL_W'(count_after);
		end
	end

	// A request pushed into an empty queue leaves in the same item.
	assign entry_s1 = fwd_s1 ? fwd_data_s1 : q_rdata;

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_kind_q  <= kind_s1;
			out_level_q <= level_s1;
			if (kind_s1 == rriwd_pkg::KIND_DISPATCH) begin
				out_tgt_q <= rriwd_pkg::WIDX_W'(tgt_s1);
				out_id_q  <= entry_s1[rriwd_pkg::ENTRY_W-1:rriwd_pkg::TOK_W];
				out_tok_q <= entry_s1[rriwd_pkg::TOK_W-1:0];
			end else begin
				out_tgt_q <= '0;
				out_id_q  <= '0;
				out_tok_q <= '0;
			end
		end
	end

	assign res.valid         = out_valid_q;
	assign res.kind          = out_kind_q;
	assign res.target_worker = out_tgt_q;
	assign res.sent_id       = out_id_q;
	assign res.sent_tokens   = out_tok_q;
	assign res.queue_level   = out_level_q;

	`RRIWD_ASSERT_NEXT(a_stop_holds, stopped_q, stopped_q, "stop mark cleared without reset")
	`RRIWD_ASSERT_NOW(a_target_busy,
		state_q == rriwd_pkg::S_READ && kind_s1 == rriwd_pkg::KIND_DISPATCH,
		busy_q[tgt_s1], "dispatched worker is not marked busy")
	`RRIWD_ASSERT_NEXT(a_item_read, cmd_acc, state_q == rriwd_pkg::S_READ,
		"accepted item did not enter the read stage")

endmodule

`default_nettype wire

>>> rtl/rriwd_pick.sv
// Rotating idle-worker search: first idle worker at or after the start
// position among active workers, else the lowest; depends on nothing.
`default_nettype none

module rriwd_pick #(
	parameter int MAX_WORKERS = 16
) (
	input  wire logic [MAX_WORKERS-1:0]             busy,
	input  wire logic [$clog2(MAX_WORKERS+1)-1:0]   count_n,
	input  wire logic [$clog2(MAX_WORKERS)-1:0]     start,
	output      logic                               found,
	output      logic [$clog2(MAX_WORKERS)-1:0]     idx
);

	localparam int WW = $clog2(MAX_WORKERS);

	logic [MAX_WORKERS-1:0] idle;
	logic [MAX_WORKERS-1:0] idle_hi;
	logic [WW-1:0]          idx_hi;
	logic [WW-1:0]          idx_any;

	// Idle among the active workers, and the part at or after the start.
	always_comb begin
		for (int i = 0; i < MAX_WORKERS; i++) begin
			idle[i]    = !busy[i] && (i < int'(count_n));
			idle_hi[i] = idle[i] && (i >= int'(start));
		end
	end

	// Lowest set bit of each mask; the upper part wins when it has one.
	always_comb begin
		idx_hi  = '0;
		idx_any = '0;
		for (int i = MAX_WORKERS - 1; i >= 0; i--) begin
			if (idle_hi[i]) begin
				idx_hi = WW'(i);
			end
			if (idle[i]) begin
				idx_any = WW'(i);
			end
		end
	end

	assign found = |idle;
	assign idx   = (|idle_hi) ? idx_hi : idx_any;

endmodule

`default_nettype wire

>>> rtl/rriwd_queue.sv
// Request queue of the dispatcher: a synchronous memory with head and tail
// pointers and a fill count. Depends on rriwd_pkg and the assertion header.
`default_nettype none

`include "round_robin_idle_worker_dispatcher_unit_assert.svh"

module rriwd_queue #(
	parameter int QUEUE_DEPTH = rriwd_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire rriwd_pkg::queue_ctrl_t              ctrl,
	input  wire logic [rriwd_pkg::ENTRY_W-1:0]       wdata,
	output      logic [rriwd_pkg::ENTRY_W-1:0]       rdata,
	output      logic [$clog2(QUEUE_DEPTH+1)-1:0]    count
);

	localparam int QW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic [rriwd_pkg::ENTRY_W-1:0] mem [QUEUE_DEPTH];
	logic [rriwd_pkg::ENTRY_W-1:0] rdata_q;
	logic [QW-1:0]                 head_q;
	logic [QW-1:0]                 tail_q;
	logic [CW-1:0]                 count_q;

	// Memory write port at the tail.
	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			mem[tail_q] <= wdata;
		end
	end

	// Memory read port at the head; the old entry is read on a same-slot write.
	always_ff @(posedge clk) begin
		if (ctrl.pop) begin
			rdata_q <= mem[head_q];
		end
	end

	// Pointers wrap at the depth, which need not be a power of two.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (ctrl.push) begin
				tail_q <= (tail_q == QW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + QW'(1);
			end
			if (ctrl.pop) begin
				head_q <= (head_q == QW'(QUEUE_DEPTH - 1)) ? '0 : head_q + QW'(1);
			end
			if (ctrl.push && !ctrl.pop) begin
				count_q <= count_q + CW'(1);
			end else if (ctrl.pop && !ctrl.push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	assign rdata = rdata_q;
	assign count = count_q;

	// A pop together with a push into an empty queue is the pass-through case.
	`RRIWD_ASSERT_NOW(a_pop_nonempty, ctrl.pop && !ctrl.push, count_q != '0,
		"pop from an empty queue")
	`RRIWD_ASSERT_NOW(a_push_room, ctrl.push && !ctrl.pop, count_q != CW'(QUEUE_DEPTH),
		"push into a full queue")
	`RRIWD_ASSERT_NEXT(a_push_count, ctrl.push && !ctrl.pop,
		count_q == $past(count_q) + CW'(1), "fill count missed a push")

endmodule

`default_nettype wire

>>> dv/tb.sv
// Testbench of the round-robin idle-worker dispatcher: a directed opening, a queue flood and
// random phases over several worker counts, each result checked against an in-bench predictor.
// Depends on rriwd_pkg, the channel interfaces in rriwd_if and the dispatcher top level.

module tb;
	import rriwd_pkg::*;

	localparam int QDEPTH      = QUEUE_DEPTH_DEF;
	localparam int NWORK       = MAX_WORKERS_DEF;
	localparam int STALL_LIMIT = 1000;
	localparam int PHASE_ITEMS = 130;

	typedef struct packed {
		cmd_e_t              command;
		logic [ID_W-1:0]     request_id;
		logic [TOK_W-1:0]    token_count;
		logic [WIDX_W-1:0]   done_worker;
	} job_t;

	typedef struct packed {
		kind_e_t             kind;
		logic [WIDX_W-1:0]   target_worker;
		logic [ID_W-1:0]     sent_id;
		logic [TOK_W-1:0]    sent_tokens;
		logic [LEVEL_W-1:0]  queue_level;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n;

	rriwd_cmd_if cmd_ch();
	rriwd_res_if res_ch();
	rriwd_cfg_if cfg_ch();

	round_robin_idle_worker_dispatcher_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	always #5 clk = ~clk;

	// Predictor state: worker pool, rotating start, waiting requests and end marks.
	logic [WC_W-1:0]  pool_size;
	logic [NWORK-1:0] busy_mask;
	int unsigned      next_start;
	logic [ID_W-1:0]  held_id  [QDEPTH];
	logic [TOK_W-1:0] held_tok [QDEPTH];
	int unsigned      head_pos;
	int unsigned      tail_pos;
	int unsigned      held_count;
	bit               input_closed;
	bit               halted;

	// Stimulus and scoreboard bookkeeping.
	job_t        waiting_jobs[$];
	outcome_t    awaited[$];
	job_t        next_job;
	job_t        taken_job;
	outcome_t    want;
	int unsigned items_queued = 0;
	int unsigned items_taken  = 0;
	int unsigned fail_count   = 0;
	int unsigned quiet_cycles = 0;
	int unsigned gap_left     = 0;
	int unsigned stall_left   = 0;
	bit          cmd_taken    = 1'b0;
	bit          cfg_taken    = 1'b0;
	bit          res_taken    = 1'b0;
	bit          cmd_idle;
	bit          res_idle;

	function automatic int unsigned workers_in_use();
		if (pool_size == '0) return 1;
		if (pool_size > NWORK) return NWORK;
		return pool_size;
	endfunction

	// Hands the oldest waiting request to the first idle worker from the rotating start.
	function automatic bit hand_out(inout outcome_t o);
		int unsigned n;
		int unsigned w;
		n = workers_in_use();
		if (held_count == 0) return 1'b0;
		for (int unsigned k = 0; k < n; k++) begin
			w = (next_start + k) % n;
			if (!busy_mask[w]) begin
				o.kind          = KIND_DISPATCH;
				o.target_worker = WIDX_W'(w);
				o.sent_id       = held_id[head_pos];
				o.sent_tokens   = held_tok[head_pos];
				head_pos        = (head_pos + 1) % QDEPTH;
				held_count--;
				busy_mask[w]    = 1'b1;
				next_start      = (w + 1) % n;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic void hold_request(logic [ID_W-1:0] id, logic [TOK_W-1:0] tok);
		held_id[tail_pos]  = id;
		held_tok[tail_pos] = tok;
		tail_pos           = (tail_pos + 1) % QDEPTH;
		held_count++;
	endfunction

	// Works out the one result item that an accepted item gives.
	function automatic outcome_t predict_dispatch(job_t j);
		outcome_t o;
		bit settled;
		o = '0;
		settled = 1'b0;
		if (!halted) begin
			case (j.command)
				CMD_REQUEST: begin
					if (held_count >= QDEPTH) begin
						// A full queue only takes the request if the head can leave first.
						if (hand_out(o)) hold_request(j.request_id, j.token_count);
						else o.kind = KIND_DROPPED;
						settled = 1'b1;
					end else begin
						hold_request(j.request_id, j.token_count);
					end
				end
				CMD_DONE: begin
					if (!busy_mask[j.done_worker]) begin
						o.kind = KIND_BAD_DONE;
						settled = 1'b1;
					end else begin
						busy_mask[j.done_worker] = 1'b0;
					end
				end
				CMD_END: begin
					input_closed = 1'b1;
				end
				default: begin
				end
			endcase
			// The stop test looks at every busy flag, not only those of the active pool.
			if (!settled && !hand_out(o) && input_closed && held_count == 0
					&& busy_mask == '0) begin
				halted = 1'b1;
				o.kind = KIND_STOP;
			end
		end
		o.queue_level = LEVEL_W'(held_count);
		return o;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic void add_item(cmd_e_t c, logic [ID_W-1:0] id, logic [TOK_W-1:0] tok,
			logic [WIDX_W-1:0] w);
		job_t j;
		j.command     = c;
		j.request_id  = id;
		j.token_count = tok;
		j.done_worker = w;
		waiting_jobs  = {waiting_jobs, j};
		items_queued++;
	endfunction

	// Random item: mostly requests and completions from the active pool, a few stray ones.
	function automatic void add_random(int unsigned req_pct, int unsigned active);
		int unsigned r;
		logic [WIDX_W-1:0] w;
		r = $urandom_range(0, 99);
		w = ($urandom_range(0, 4) == 0) ? WIDX_W'($urandom)
			: WIDX_W'($urandom_range(0, active - 1));
		if (r < req_pct) add_item(CMD_REQUEST, $urandom, TOK_W'($urandom), WIDX_W'($urandom));
		else if (r < 96) add_item(CMD_DONE, $urandom, TOK_W'($urandom), w);
		else add_item(CMD_TICK, $urandom, TOK_W'($urandom), WIDX_W'($urandom));
	endfunction

	function automatic void flag_field(string field, logic [63:0] exp_v, logic [63:0] got_v);
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, got_v);
		fail_count++;
	endfunction

	// Waits until every queued item has been taken and every result has come back.
	task automatic wait_drained();
		while (items_taken != items_queued || awaited.size() != 0) @(negedge clk);
	endtask

	task automatic write_count(logic [WC_W-1:0] v);
		cfg_ch.valid        <= 1'b1;
		cfg_ch.worker_total <= v;
		do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// Command driver: presents queued items, with random gaps between them while cmd_idle is set.
	always @(negedge clk) begin
		if (arst_n) begin
			if (cmd_taken) gap_left = cmd_idle ? pick_gap() : 0;
			if (cmd_taken || !cmd_ch.valid) begin
				if (gap_left > 0) begin
					gap_left--;
					cmd_ch.valid <= 1'b0;
				end else if (waiting_jobs.size() > 0) begin
					next_job = waiting_jobs.pop_front();
					cmd_ch.valid       <= 1'b1;
					cmd_ch.command     <= next_job.command;
					cmd_ch.request_id  <= next_job.request_id;
					cmd_ch.token_count <= next_job.token_count;
					cmd_ch.done_worker <= next_job.done_worker;
				end else begin
					cmd_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result receiver: stalls at random while res_idle is set.
	always @(negedge clk) begin
		if (arst_n) begin
			if (res_idle && stall_left > 0) begin
				stall_left--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
				if (res_idle) stall_left = pick_gap();
			end
		end
	end

	// Monitor: predicts on each accepted item, checks each result item, and guards progress.
	always @(posedge clk) begin
		if (arst_n) begin
			cmd_taken = cmd_ch.valid && cmd_ch.ready;
			cfg_taken = cfg_ch.valid && cfg_ch.ready;
			res_taken = res_ch.valid && res_ch.ready;
			if (cmd_taken) begin
				taken_job.command     = cmd_e_t'(cmd_ch.command);
				taken_job.request_id  = cmd_ch.request_id;
				taken_job.token_count = cmd_ch.token_count;
				taken_job.done_worker = cmd_ch.done_worker;
				awaited = {awaited, predict_dispatch(taken_job)};
				items_taken++;
			end
			if (cfg_taken) pool_size = cfg_ch.worker_total;
			if (res_taken) begin
				if (awaited.size() == 0) begin
					$display("%0t: result item with none expected, actual kind %0d", $time,
						res_ch.kind);
					fail_count++;
				end else begin
					want = awaited.pop_front();
					if (res_ch.kind !== want.kind)
						flag_field("kind", want.kind, res_ch.kind);
					if (res_ch.target_worker !== want.target_worker)
						flag_field("target_worker", want.target_worker, res_ch.target_worker);
					if (res_ch.sent_id !== want.sent_id)
						flag_field("sent_id", want.sent_id, res_ch.sent_id);
					if (res_ch.sent_tokens !== want.sent_tokens)
						flag_field("sent_tokens", want.sent_tokens, res_ch.sent_tokens);
					if (res_ch.queue_level !== want.queue_level)
						flag_field("queue_level", want.queue_level, res_ch.queue_level);
				end
			end
			if (cmd_taken || cfg_taken || res_taken) quiet_cycles = 0;
			else quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// Stimulus: directed opening, queue flood, random phases, then end of input and drain.
	initial begin
		int unsigned act;
		logic [WC_W-1:0] phase_count [8];

		arst_n              = 1'b0;
		cmd_ch.valid        = 1'b0;
		cmd_ch.command      = CMD_TICK;
		cmd_ch.request_id   = '0;
		cmd_ch.token_count  = '0;
		cmd_ch.done_worker  = '0;
		res_ch.ready        = 1'b0;
		cfg_ch.valid        = 1'b0;
		cfg_ch.worker_total = '0;
		pool_size           = WC_RESET;
		busy_mask           = '0;
		next_start          = 0;
		head_pos            = 0;
		tail_pos            = 0;
		held_count          = 0;
		input_closed        = 1'b0;
		halted              = 1'b0;
		cmd_idle            = 1'b1;
		res_idle            = 1'b1;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Full pool: extreme field values, a completion, idle completions and an idle tick.
		add_item(CMD_REQUEST, '0, '0, '0);
		add_item(CMD_REQUEST, '1, '1, '1);
		add_item(CMD_DONE, $urandom, TOK_W'($urandom), 4'd0);
		add_item(CMD_DONE, $urandom, TOK_W'($urandom), 4'd0);
		add_item(CMD_DONE, $urandom, TOK_W'($urandom), 4'd15);
		add_item(CMD_TICK, '1, '1, '1);
		repeat (4) add_item(CMD_REQUEST, $urandom, TOK_W'($urandom), WIDX_W'($urandom));
		add_item(CMD_DONE, '0, '0, 4'd1);

		// Two workers: a queued request, a completion from beyond the pool, a stray one.
		wait_drained();
		write_count(5'd2);
		repeat (3) add_item(CMD_REQUEST, $urandom, TOK_W'($urandom), WIDX_W'($urandom));
		add_item(CMD_DONE, '0, '0, 4'd4);
		add_item(CMD_DONE, '0, '0, 4'd0);
		add_item(CMD_DONE, '0, '0, 4'd9);
		add_item(CMD_TICK, '0, '0, '0);

		// A count of zero acts as one worker; flood the queue past its depth.
		wait_drained();
		write_count(5'd0);
		repeat (QDEPTH + 4)
			add_item(CMD_REQUEST, $urandom, TOK_W'($urandom), WIDX_W'($urandom));

		phase_count[0] = 5'd31;
		phase_count[1] = 5'd1;
		phase_count[2] = 5'd17;
		phase_count[3] = 5'd4;
		phase_count[4] = WC_W'($urandom);
		phase_count[5] = 5'd2;
		phase_count[6] = WC_W'($urandom);
		phase_count[7] = 5'd16;
		for (int p = 0; p < 8; p++) begin
			wait_drained();
			write_count(phase_count[p]);
			cmd_idle = (p % 3 != 0);
			res_idle = (p % 3 != 1);
			// The first item after widening the pool meets a full queue with idle workers.
			if (p == 0) add_item(CMD_REQUEST, $urandom, TOK_W'($urandom), WIDX_W'($urandom));
			act = (phase_count[p] == '0) ? 1
				: ((phase_count[p] > NWORK) ? NWORK : phase_count[p]);
			repeat (PHASE_ITEMS) add_random((p % 2 == 1) ? 65 : 45, act);
		end

		// Shrink the pool while wider workers are still busy, end input, then drain.
		wait_drained();
		write_count(5'd3);
		cmd_idle = 1'b1;
		res_idle = 1'b1;
		repeat (20) add_random(45, 3);
		add_item(CMD_END, $urandom, TOK_W'($urandom), WIDX_W'($urandom));
		repeat (10) add_random(45, 3);
		repeat (30) begin
			for (int w = 0; w < 3; w++) add_item(CMD_DONE, '0, '0, WIDX_W'(w));
		end
		for (int w = 0; w < NWORK; w++) add_item(CMD_DONE, '0, '0, WIDX_W'(w));
		// Items after stop-all are ignored.
		add_item(CMD_TICK, '0, '0, '0);
		add_item(CMD_REQUEST, $urandom, TOK_W'($urandom), WIDX_W'($urandom));
		add_item(CMD_END, '0, '0, '0);
		add_item(CMD_DONE, '0, '0, 4'd0);

		wait_drained();
		repeat (10) @(posedge clk);
		if (fail_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
